[rtl/pcbn_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbn_pkg - shared definitions for the point cloud box normalizer
// Command codes, widths, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
package pcbn_pkg;

    // Item command codes
    localparam logic [1:0] CMD_CLEAR   = 2'd0;
    localparam logic [1:0] CMD_MEASURE = 2'd1;
    localparam logic [1:0] CMD_NORM    = 2'd2;

    // Widths
    localparam int COORD_W   = 16;             // Q7.8 input, Q1.14 output
    localparam int SF_W      = 24;             // scale factor, floor(2^23 / E)
    localparam int DIV_STEPS = SF_W;           // one quotient bit per step
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int PROD_W    = COORD_W + 1 + SF_W + 1;
    localparam int OUT_MAX   = 16384;          // +1.0 in Q1.14

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIV,
        ST_MUL,
        ST_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic clear;
        logic measure;
        logic capture;
        logic calc;
        logic div_step;
        logic mul;
        logic emit;
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic factor_ready;
        logic ext_zero;
        logic div_last;
        logic out_busy;
    } t_dp_status;

endpackage

[rtl/pcbn_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbn_ctrl - sequencing controller
// Decodes input items and steps a normalize item through factor latch,
// division, multiply and output load.
// ----------------------------------------------------------------------------
module pcbn_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [1:0]            i_cmd,
    output logic                  o_ready,
    input  pcbn_pkg::t_dp_status  i_status,
    output pcbn_pkg::t_ctrl_cmd   o_cmd
);

    pcbn_pkg::t_state r_state;
    pcbn_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcbn_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            pcbn_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    case (i_cmd)
                        pcbn_pkg::CMD_CLEAR:   o_cmd.clear   = 1'b1;
                        pcbn_pkg::CMD_MEASURE: o_cmd.measure = 1'b1;
                        pcbn_pkg::CMD_NORM: begin
                            o_cmd.capture = 1'b1;
                            n_state = i_status.factor_ready ? pcbn_pkg::ST_MUL
                                                            : pcbn_pkg::ST_CALC;
                        end
                        default: ;  // unused code: item dropped
                    endcase
                end
            end
            pcbn_pkg::ST_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = pcbn_pkg::ST_DIV;
            end
            pcbn_pkg::ST_DIV: begin
                // zero extent leaves the factor at zero
                if (i_status.ext_zero) begin
                    n_state = pcbn_pkg::ST_MUL;
                end else begin
                    o_cmd.div_step = 1'b1;
                    if (i_status.div_last) begin
                        n_state = pcbn_pkg::ST_MUL;
                    end
                end
            end
            pcbn_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = pcbn_pkg::ST_EMIT;
            end
            pcbn_pkg::ST_EMIT: begin
                if (!i_status.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = pcbn_pkg::ST_IDLE;
                end
            end
            default: n_state = pcbn_pkg::ST_IDLE;
        endcase
    end

endmodule

[rtl/pcbn_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbn_dpath - bounding box, factor divider and scaling datapath
// Holds the box, latches center and scale factor (bit-serial restoring
// divide), scales a captured point and keeps the output register.
// ----------------------------------------------------------------------------
module pcbn_dpath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pcbn_pkg::t_ctrl_cmd               i_cmd,
    output pcbn_pkg::t_dp_status              o_status,
    input  logic signed [pcbn_pkg::COORD_W-1:0] i_x_in,
    input  logic signed [pcbn_pkg::COORD_W-1:0] i_y_in,
    input  logic signed [pcbn_pkg::COORD_W-1:0] i_z_in,
    input  logic                              i_ready,
    output logic                              o_valid,
    output logic signed [pcbn_pkg::COORD_W-1:0] o_x_out,
    output logic signed [pcbn_pkg::COORD_W-1:0] o_y_out,
    output logic signed [pcbn_pkg::COORD_W-1:0] o_z_out,
    output logic                              o_degenerate
);

    localparam int CW = pcbn_pkg::COORD_W;
    localparam int SW = pcbn_pkg::SF_W;
    localparam int PW = pcbn_pkg::PROD_W;
    localparam int QW = PW - 8;
    localparam logic signed [QW-1:0] Q_MAX = QW'(pcbn_pkg::OUT_MAX);
    localparam logic signed [QW-1:0] Q_MIN = -Q_MAX;
    localparam logic [pcbn_pkg::CNT_W-1:0] CNT_LAST =
        pcbn_pkg::CNT_W'(pcbn_pkg::DIV_STEPS - 1);

    // Box, latched factor and captured point
    logic signed [CW-1:0] r_lo  [3];
    logic signed [CW-1:0] r_hi  [3];
    logic signed [CW-1:0] r_ctr [3];
    logic signed [CW-1:0] r_pt  [3];
    logic signed [CW-1:0] n_lo  [3];
    logic signed [CW-1:0] n_hi  [3];
    logic signed [CW-1:0] n_ctr [3];
    logic signed [CW-1:0] n_pt  [3];
    logic                 r_any, n_any;
    logic                 r_fr,  n_fr;
    logic [SW-1:0]        r_sf,  n_sf;

    // Divider
    logic [CW-1:0]        r_ext, n_ext;
    logic [CW-1:0]        r_rem, n_rem;
    logic [SW-1:0]        r_quo, n_quo;
    logic [pcbn_pkg::CNT_W-1:0] r_cnt, n_cnt;

    // Products and output register
    logic signed [PW-1:0] r_prod [3];
    logic signed [PW-1:0] n_prod [3];
    logic                 r_valid;
    logic signed [CW-1:0] r_out [3];
    logic                 r_deg;

    logic signed [CW-1:0] w_in   [3];
    logic signed [CW:0]   w_sum  [3];
    logic [CW:0]          w_span [3];
    logic [CW-1:0]        w_emax;
    logic [CW:0]          w_rsh;
    logic                 w_ge;
    logic signed [CW:0]   w_diff [3];
    logic signed [QW-1:0] w_q    [3];
    logic signed [CW-1:0] w_sat  [3];

    assign w_in[0] = i_x_in;
    assign w_in[1] = i_y_in;
    assign w_in[2] = i_z_in;

    // Box middle, per-axis extent and largest extent
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_sum[a]  = {r_hi[a][CW-1], r_hi[a]} + {r_lo[a][CW-1], r_lo[a]};
            w_span[a] = {r_hi[a][CW-1], r_hi[a]} - {r_lo[a][CW-1], r_lo[a]};
        end
        w_emax = w_span[0][CW-1:0];
        if (w_span[1][CW-1:0] > w_emax) w_emax = w_span[1][CW-1:0];
        if (w_span[2][CW-1:0] > w_emax) w_emax = w_span[2][CW-1:0];
    end

    // Restoring divide step: dividend 2^23 feeds a one on the first step
    assign w_rsh = {r_rem, (r_cnt == '0)};
    assign w_ge  = w_rsh >= {1'b0, r_ext};

    // Re-center and scale, then floor-shift and saturate
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_diff[a] = {r_pt[a][CW-1], r_pt[a]} - {r_ctr[a][CW-1], r_ctr[a]};
            n_prod[a] = w_diff[a] * $signed({1'b0, r_sf});
            w_q[a]    = r_prod[a][PW-1:8];
            if (w_q[a] > Q_MAX) begin
                w_sat[a] = Q_MAX[CW-1:0];
            end else if (w_q[a] < Q_MIN) begin
                w_sat[a] = Q_MIN[CW-1:0];
            end else begin
                w_sat[a] = w_q[a][CW-1:0];
            end
        end
    end

    // Next state of box, factor and divider
    always_comb begin
        n_lo  = r_lo;
        n_hi  = r_hi;
        n_ctr = r_ctr;
        n_pt  = r_pt;
        n_any = r_any;
        n_fr  = r_fr;
        n_sf  = r_sf;
        n_ext = r_ext;
        n_rem = r_rem;
        n_quo = r_quo;
        n_cnt = r_cnt;
        if (i_cmd.clear) begin
            for (int a = 0; a < 3; a++) begin
                n_lo[a]  = '0;
                n_hi[a]  = '0;
                n_ctr[a] = '0;
            end
            n_any = 1'b0;
            n_fr  = 1'b0;
            n_sf  = '0;
        end
        if (i_cmd.measure) begin
            for (int a = 0; a < 3; a++) begin
                if (!r_any || w_in[a] < r_lo[a]) n_lo[a] = w_in[a];
                if (!r_any || w_in[a] > r_hi[a]) n_hi[a] = w_in[a];
            end
            n_any = 1'b1;
            n_fr  = 1'b0;
        end
        if (i_cmd.capture) begin
            for (int a = 0; a < 3; a++) n_pt[a] = w_in[a];
        end
        // Latch center; empty box gives zero center and zero extent
        if (i_cmd.calc) begin
            for (int a = 0; a < 3; a++) begin
                n_ctr[a] = r_any ? w_sum[a][CW:1] : '0;
            end
            n_ext = r_any ? w_emax : '0;
            n_sf  = '0;
            n_fr  = 1'b1;
            n_rem = '0;
            n_quo = '0;
            n_cnt = '0;
        end
        if (i_cmd.div_step) begin
            n_rem = w_ge ? CW'(w_rsh - {1'b0, r_ext}) : w_rsh[CW-1:0];
            n_quo = {r_quo[SW-2:0], w_ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_LAST) n_sf = {r_quo[SW-2:0], w_ge};
        end
    end

    // Control state and box registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_lo[a]  <= '0;
                r_hi[a]  <= '0;
                r_ctr[a] <= '0;
            end
            r_any   <= 1'b0;
            r_fr    <= 1'b0;
            r_sf    <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_lo  <= n_lo;
            r_hi  <= n_hi;
            r_ctr <= n_ctr;
            r_any <= n_any;
            r_fr  <= n_fr;
            r_sf  <= n_sf;
            r_cnt <= n_cnt;
            if (i_cmd.emit) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pt  <= n_pt;
        r_ext <= n_ext;
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_cmd.mul) r_prod <= n_prod;
        if (i_cmd.emit) begin
            r_deg <= (r_sf == '0);
            for (int a = 0; a < 3; a++) begin
                r_out[a] <= (r_sf == '0) ? '0 : w_sat[a];
            end
        end
    end

    assign o_status.factor_ready = r_fr;
    assign o_status.ext_zero     = (r_ext == '0);
    assign o_status.div_last     = (r_cnt == CNT_LAST);
    assign o_status.out_busy     = r_valid && !i_ready;

    assign o_valid      = r_valid;
    assign o_x_out      = r_out[0];
    assign o_y_out      = r_out[1];
    assign o_z_out      = r_out[2];
    assign o_degenerate = r_deg;

endmodule

[rtl/point_cloud_box_normalizer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_cloud_box_normalizer_top - bounding box normalization to unit cube
// Measures a per-axis box over Q7.8 points, then maps points into [-1,1]
// as Q1.14 around the box middle, scaled by 2 over the largest extent.
// ----------------------------------------------------------------------------
// Clear, measure and unused-code items may follow back to back. A normalize
// item steps through capture, multiply and output load when the factor is
// already latched. The first normalize after a clear or a measure also
// latches center and factor first, by the 24-step restoring divider, one
// quotient bit a cycle, skipped when the box is empty or has no extent.
// The input is held off while a normalize item is in flight; the output
// register lets the next items enter while a result waits, and a normalize
// waits in its last step until that register frees. Reset clears the box
// and the latched factor.
module point_cloud_box_normalizer_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [1:0]                         i_cmd,
    input  logic signed [pcbn_pkg::COORD_W-1:0] i_x_in,
    input  logic signed [pcbn_pkg::COORD_W-1:0] i_y_in,
    input  logic signed [pcbn_pkg::COORD_W-1:0] i_z_in,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [pcbn_pkg::COORD_W-1:0] o_x_out,
    output logic signed [pcbn_pkg::COORD_W-1:0] o_y_out,
    output logic signed [pcbn_pkg::COORD_W-1:0] o_z_out,
    output logic                               o_degenerate
);

    pcbn_pkg::t_ctrl_cmd  w_cmd;
    pcbn_pkg::t_dp_status w_status;

    pcbn_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_cmd    (i_cmd),
        .o_ready  (o_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    pcbn_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_x_in       (i_x_in),
        .i_y_in       (i_y_in),
        .i_z_in       (i_z_in),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_x_out      (o_x_out),
        .o_y_out      (o_y_out),
        .o_z_out      (o_z_out),
        .o_degenerate (o_degenerate)
    );

endmodule

[rtl/pcbn_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbn_checker - port-level assertions for the normalizer
// Watches the top level ports; attached by the bind below.
// ----------------------------------------------------------------------------
module pcbn_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               o_ready,
    input logic [1:0]                         i_cmd,
    input logic signed [pcbn_pkg::COORD_W-1:0] i_x_in,
    input logic signed [pcbn_pkg::COORD_W-1:0] i_y_in,
    input logic signed [pcbn_pkg::COORD_W-1:0] i_z_in,
    input logic                               o_valid,
    input logic                               i_ready,
    input logic signed [pcbn_pkg::COORD_W-1:0] o_x_out,
    input logic signed [pcbn_pkg::COORD_W-1:0] o_y_out,
    input logic signed [pcbn_pkg::COORD_W-1:0] o_z_out,
    input logic                               o_degenerate
);

    localparam logic signed [pcbn_pkg::COORD_W-1:0] LIM =
        pcbn_pkg::COORD_W'(pcbn_pkg::OUT_MAX);

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_x_out) && $stable(o_y_out)
            && $stable(o_z_out) && $stable(o_degenerate))
        else $error("output item changed while stalled");

    // Degenerate result carries zero coordinates
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_x_out == '0 && o_y_out == '0 && o_z_out == '0)
        else $error("degenerate item with nonzero coordinates");

    // Coordinates stay within [-1, 1]
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_x_out <= LIM && o_x_out >= -LIM && o_y_out <= LIM
            && o_y_out >= -LIM && o_z_out <= LIM && o_z_out >= -LIM)
        else $error("normalized coordinate out of range");

    // Normalize item holds off the input on the following cycle
    a_norm_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_cmd == pcbn_pkg::CMD_NORM |=> !o_ready)
        else $error("input accepted while normalize in flight");

endmodule

bind point_cloud_box_normalizer_top pcbn_checker u_pcbn_checker (.*);
